>>> hdl/median_zone_hysteresis_filter_defines.svh
// assertion macros for the median zone hysteresis filter
`ifndef MEDIAN_ZONE_HYSTERESIS_FILTER_DEFINES_SVH
`define MEDIAN_ZONE_HYSTERESIS_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MZHF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mzhf same-cycle check failed");
`define MZHF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mzhf next-cycle check failed");
`else
`define MZHF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MZHF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/mzhf_pkg.sv
// types and constants shared by the median zone hysteresis filter
`timescale 1ns / 1ps
package mzhf_pkg;

    localparam int DIST_W = 12;
    localparam int HYST_W = 10;
    localparam int PROD_W = DIST_W + HYST_W;
    localparam int DIST_MAX = (1 << DIST_W) - 1;
    localparam int PERMILLE_SCALE = 1000;

    localparam logic [DIST_W-1:0] RED_RESET = 12'd480;
    localparam logic [DIST_W-1:0] YELLOW_RESET = 12'd1600;
    localparam logic [HYST_W-1:0] HYST_RESET = 10'd20;

    typedef enum logic [1:0] {
        ZONE_GREEN  = 2'd0,
        ZONE_YELLOW = 2'd1,
        ZONE_RED    = 2'd2
    } t_zone;

    typedef enum logic [1:0] {
        REG_RED    = 2'd0,
        REG_YELLOW = 2'd1,
        REG_HYST   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DIST_W-1:0] red;
        logic [DIST_W-1:0] yellow;
        logic [HYST_W-1:0] hyst;
    } t_cfg;

    typedef struct packed {
        logic              emit;
        logic [DIST_W-1:0] distance;
        t_zone             zone;
        logic              error;
    } t_result;

endpackage

>>> hdl/mzhf_window.sv
// sample ring and rank network giving the upper median of the filled entries
`timescale 1ns / 1ps
module mzhf_window #(
    parameter int WINDOW = 5,
    parameter int MAX_DISTANCE_CM = 165
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_commit,
    input  logic [mzhf_pkg::DIST_W-1:0] i_raw,
    output logic [mzhf_pkg::DIST_W-1:0] o_median
);
    import mzhf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int LIMIT_FULL = MAX_DISTANCE_CM * 16;
    localparam int LIMIT = (LIMIT_FULL > DIST_MAX) ? DIST_MAX : LIMIT_FULL;
    localparam logic [DIST_W-1:0] LIMIT_V = DIST_W'(LIMIT);

    logic [DIST_W-1:0] r_window [WINDOW];
    logic [IDX_W-1:0]  r_wr_idx;
    logic              r_full;
    logic [IDX_W-1:0]  n_wr_idx;
    logic              n_full;

    logic [DIST_W-1:0] sat;
    logic [DIST_W-1:0] new_win [WINDOW];
    logic [WINDOW-1:0] valid;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  rank [WINDOW];

    assign sat = (i_raw > LIMIT_V) ? LIMIT_V : i_raw;

    // window as it stands once this beat is written
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            new_win[i] = (IDX_W'(i) == r_wr_idx) ? sat : r_window[i];
            valid[i] = r_full || (IDX_W'(i) <= r_wr_idx);
        end
        count = r_full ? CNT_W'(WINDOW) : CNT_W'(r_wr_idx) + CNT_W'(1);
        half = count >> 1;
    end

    // ties broken by slot position so every filled entry gets a distinct rank
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if (j != i && valid[j] &&
                    (new_win[j] < new_win[i] || (new_win[j] == new_win[i] && j < i))) begin
                    rank[i] = rank[i] + CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (valid[i] && rank[i] == half) begin
                o_median = o_median | new_win[i];
            end
        end
    end

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_full = r_full;
        if (i_commit) begin
            if (r_wr_idx == IDX_W'(WINDOW - 1)) begin
                n_wr_idx = '0;
                n_full = 1'b1;
            end else begin
                n_wr_idx = r_wr_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_full <= 1'b0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_window[r_wr_idx] <= sat;
        end
    end

endmodule

>>> hdl/mzhf_report.sv
// zone classification and relative change test deciding whether a beat reports
`timescale 1ns / 1ps
module mzhf_report (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_commit,
    input  logic                        i_err,
    input  logic [mzhf_pkg::DIST_W-1:0] i_median,
    input  mzhf_pkg::t_cfg              i_cfg,
    output mzhf_pkg::t_result           o_res
);
    import mzhf_pkg::*;

    logic [DIST_W-1:0] r_last;
    logic              r_last_valid;
    t_zone             r_last_zone;
    logic [DIST_W-1:0] n_last;
    logic              n_last_valid;
    t_zone             n_last_zone;

    t_zone             zone;
    logic [DIST_W-1:0] diff;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    logic              moved;
    logic              report;

    always_comb begin
        priority if (i_median <= i_cfg.red) begin
            zone = ZONE_RED;
        end else if (i_median <= i_cfg.yellow) begin
            zone = ZONE_YELLOW;
        end else begin
            zone = ZONE_GREEN;
        end
    end

    // |m - last| * 1000 >= hyst * last, exact in integers
    assign diff = (i_median > r_last) ? (i_median - r_last) : (r_last - i_median);
    assign lhs = PROD_W'(diff) * PROD_W'(PERMILLE_SCALE);
    assign rhs = PROD_W'(i_cfg.hyst) * PROD_W'(r_last);
    assign moved = r_last_valid && (r_last != '0) && (lhs >= rhs);
    assign report = !r_last_valid || (zone != r_last_zone) || moved;

    always_comb begin
        if (i_err) begin
            o_res.emit = 1'b1;
            o_res.distance = '0;
            o_res.zone = ZONE_GREEN;
            o_res.error = 1'b1;
        end else begin
            o_res.emit = report;
            o_res.distance = i_median;
            o_res.zone = zone;
            o_res.error = 1'b0;
        end
    end

    always_comb begin
        n_last = r_last;
        n_last_valid = r_last_valid;
        n_last_zone = r_last_zone;
        if (i_commit) begin
            if (i_err) begin
                n_last = '0;
                n_last_valid = 1'b0;
                n_last_zone = ZONE_GREEN;
            end else if (report) begin
                n_last = i_median;
                n_last_valid = 1'b1;
                n_last_zone = zone;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_last_valid <= 1'b0;
            r_last_zone <= ZONE_GREEN;
        end else begin
            r_last <= n_last;
            r_last_valid <= n_last_valid;
            r_last_zone <= n_last_zone;
        end
    end

endmodule

>>> hdl/median_zone_hysteresis_filter.sv
// top level: input register, register port, median and report units, result register
//
// usage
// - input channel: i_in_valid with i_raw_distance / i_read_error, o_in_stall back
// - output channel: o_out_valid with o_distance / o_zone / o_error, i_out_stall back
// - an accepted beat is held in the input register; once the result register can
//   take it, the ring and the last-report state update and a report, if any, lands
//   in the result register, which drives o_out_valid
// - one beat per cycle sustained while no waiting result is stalled; the median rank
//   network and the two 12x10 bit products of the change test are combinational
// - a beat that makes no report still updates the ring and produces no output beat
// - when i_out_stall holds a waiting result, the input register holds its beat
//   and o_in_stall rises; nothing is dropped
// - reset empties the ring, forgets the last report (the next reading always
//   reports) and loads the threshold and hysteresis defaults
// - registers through the APB port: 0x0 red threshold, 0x4 yellow threshold,
//   0x8 hysteresis in per mille; write only while no beat is in flight
`timescale 1ns / 1ps
`include "median_zone_hysteresis_filter_defines.svh"
module median_zone_hysteresis_filter #(
    parameter int WINDOW = 5,
    parameter int MAX_DISTANCE_CM = 165
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [mzhf_pkg::DIST_W-1:0] i_raw_distance,
    input  logic                        i_read_error,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mzhf_pkg::DIST_W-1:0] o_distance,
    output logic [1:0]                  o_zone,
    output logic                        o_error,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mzhf_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [DIST_W-1:0] r_in_raw;
    logic              r_in_err;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_distance;
    t_zone             r_out_zone;
    logic              r_out_error;

    logic              proc;
    logic              cfg_wr;
    t_reg_idx          reg_idx;
    logic [DIST_W-1:0] median;
    t_result           res;

    // --- register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx)
            REG_RED:    prdata = 32'(r_cfg.red);
            REG_YELLOW: prdata = 32'(r_cfg.yellow);
            REG_HYST:   prdata = 32'(r_cfg.hyst);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red <= RED_RESET;
            r_cfg.yellow <= YELLOW_RESET;
            r_cfg.hyst <= HYST_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RED:    r_cfg.red <= pwdata[DIST_W-1:0];
                REG_YELLOW: r_cfg.yellow <= pwdata[DIST_W-1:0];
                REG_HYST:   r_cfg.hyst <= pwdata[HYST_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    // --- handshake: the held beat is worked on once the result register can take it
    assign proc = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_raw <= i_raw_distance;
            r_in_err <= i_read_error;
        end
    end

    mzhf_window #(
        .WINDOW          (WINDOW),
        .MAX_DISTANCE_CM (MAX_DISTANCE_CM)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (proc && !r_in_err),
        .i_raw    (r_in_raw),
        .o_median (median)
    );

    mzhf_report u_report (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (proc),
        .i_err    (r_in_err),
        .i_median (median),
        .i_cfg    (r_cfg),
        .o_res    (res)
    );

    // --- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res.emit) begin
            r_out_distance <= res.distance;
            r_out_zone <= res.zone;
            r_out_error <= res.error;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance = r_out_distance;
    assign o_zone = r_out_zone;
    assign o_error = r_out_error;

    // --- checks
    `MZHF_ASSERT_IMP(a_err_payload, i_clk, i_rst_n, o_out_valid && o_error, o_distance == '0 && o_zone == ZONE_GREEN)
    `MZHF_ASSERT_NXT(a_in_held, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_in_valid)
    `MZHF_ASSERT_NXT(a_err_reports, i_clk, i_rst_n, proc && r_in_err, o_out_valid && o_error)

endmodule
